/* hw/rtl/tlbp_pkg.sv */
package tlbp_pkg;

  localparam int EntryW   = 5;
  localparam int Entries  = 1 << EntryW;
  localparam int HistW    = 8;
  localparam int RowLen   = 1 << HistW;
  localparam int TagW     = 30;
  localparam int CtrW     = 2;
  localparam int LocalAw  = EntryW + HistW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] REG_INDEX_BITS     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HISTORY_LEN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TAG_LEN        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_CTR    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHARED_HISTORY = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHARED_CTRS    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SHARE_MODE     = 3'd6;

  localparam logic [1:0] SHARE_HIST = 2'd0;
  localparam logic [1:0] SHARE_LSB  = 2'd1;
  localparam logic [1:0] SHARE_MID  = 2'd2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic load_in;
    logic look;
    logic step;
    logic sweep;
    logic final_wr;
  } tlbp_cmd_t;

  typedef struct packed {
    logic need_alloc;
    logic sweep_last;
  } tlbp_status_t;

  function automatic logic [CtrW-1:0] ctr_step(input logic [CtrW-1:0] c, input logic tk);
    logic [CtrW-1:0] r;
    r = c;
    if (tk) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/two_level_branch_predictor_core.sv */
// A predict or a hitting update steps through lookup, step and finish; an update
// that misses in per-entry counter mode adds a sweep that re-initializes the
// 2^min(history_len, 8) counters of its row and a final write before finish.
// A new item is accepted only once the previous one is through (busy is low).
// Reset or a config write to index 0..6 clears entries, histories, counts at once.
// Results are single-cycle beats on done; the receiver cannot stall.
module two_level_branch_predictor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tlbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tlbp_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [31:0]                   branch_pc,
  input  logic [31:0]                   resolved_target,
  input  logic                          was_taken,
  input  logic [31:0]                   predicted_address,
  output logic                          done,
  output logic                          predict_taken,
  output logic [31:0]                   next_address,
  output logic                          flush_seen,
  output logic [31:0]                   branch_total,
  output logic [31:0]                   flush_total
);
  import tlbp_pkg::*;

  tlbp_cmd_t    cmd;
  tlbp_status_t status;

  tlbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status),
    .cmd(cmd), .busy(busy), .done(done)
  );

  tlbp_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .status(status),
    .opcode(opcode), .branch_pc(branch_pc), .resolved_target(resolved_target),
    .was_taken(was_taken), .predicted_address(predicted_address),
    .predict_taken(predict_taken), .next_address(next_address),
    .flush_seen(flush_seen), .branch_total(branch_total), .flush_total(flush_total)
  );

endmodule

/* hw/rtl/tlbp_ram.sv */
module tlbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tlbp_ctrl.sv */
module tlbp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tlbp_pkg::tlbp_status_t status,
  output tlbp_pkg::tlbp_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);
  import tlbp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_STEP  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_WRITE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_LOOK;
      S_LOOK:  state_next = S_STEP;
      S_STEP:  state_next = status.need_alloc ? S_ALLOC : S_FIN;
      S_ALLOC: if (status.sweep_last) state_next = S_WRITE;
      S_WRITE: state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN);

  always_comb begin
    cmd.load_in  = (state == S_IDLE) && start;
    cmd.look     = (state == S_LOOK);
    cmd.step     = (state == S_STEP);
    cmd.sweep    = (state == S_ALLOC);
    cmd.final_wr = (state == S_WRITE);
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_STEP || $past(state) == S_WRITE))
    else $error("result beat without a finished item");
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_LOOK)
    else $error("accepted item did not start lookup");

endmodule

/* hw/rtl/tlbp_dp.sv */
module tlbp_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tlbp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tlbp_pkg::CfgDataW-1:0]  cfg_data,
  input  tlbp_pkg::tlbp_cmd_t            cmd,
  output tlbp_pkg::tlbp_status_t         status,
  input  logic                           opcode,
  input  logic [31:0]                    branch_pc,
  input  logic [31:0]                    resolved_target,
  input  logic                           was_taken,
  input  logic [31:0]                    predicted_address,
  output logic                           predict_taken,
  output logic [31:0]                    next_address,
  output logic                           flush_seen,
  output logic [31:0]                    branch_total,
  output logic [31:0]                    flush_total
);
  import tlbp_pkg::*;

  logic [2:0] idx_len;
  logic [3:0] history_len;
  logic [4:0] tag_len;
  logic [1:0] initial_counter;
  logic       shared_history, shared_counters;
  logic [1:0] share_mode;

  logic        op_q, tk_q;
  logic [31:0] pc_q, tgt_q, pred_q;

  logic [EntryW-1:0] idx_q;
  logic [TagW-1:0]   tag_q;
  logic              hit_q, need_alloc;
  logic [HistW-1:0]  h_q, sweep;

  logic [Entries-1:0] entry_valid;
  logic [TagW-1:0]    entry_tag [Entries];
  logic [31:0]        entry_target [Entries];
  logic [HistW-1:0]   local_history [Entries];
  logic [HistW-1:0]   global_history;
  logic [RowLen-1:0]  gvalid;
  logic [31:0]        branch_count, flush_count;

  // lookup terms
  logic [3:0]        hl;
  logic [HistW-1:0]  hmask;
  logic [7:0]        ibmask;
  logic [EntryW-1:0] idx_c;
  logic [4:0]        tn;
  logic [31:0]       tshift;
  logic [TagW-1:0]   tmask, tag_c;
  logic              hit_c;
  logic [HistW-1:0]  hist_c, h_c;

  always_comb begin
    hl     = (history_len > 4'd8) ? 4'd8 : history_len;
    hmask  = HistW'((9'd1 << hl) - 9'd1);
    ibmask = 8'((9'd1 << idx_len) - 9'd1);
    idx_c  = pc_q[2 +: EntryW] & ibmask[EntryW-1:0];
    tn     = (tag_len > (5'd30 - 5'(idx_len))) ? (5'd30 - 5'(idx_len)) : tag_len;
    tshift = pc_q >> (6'd2 + 6'(idx_len));
    tmask  = TagW'((31'd1 << tn) - 31'd1);
    tag_c  = tshift[TagW-1:0] & tmask;
    hit_c  = entry_valid[idx_c] && (entry_tag[idx_c] == tag_c);
    if (shared_history) hist_c = global_history;
    else if (op_q == OP_UPDATE && !hit_c) hist_c = '0;
    else hist_c = local_history[idx_c];
    h_c = hist_c & hmask;
    if (shared_counters) begin
      if (share_mode == SHARE_LSB) h_c = h_c ^ (pc_q[2 +: HistW] & hmask);
      else if (share_mode == SHARE_MID) h_c = h_c ^ (pc_q[16 +: HistW] & hmask);
    end
  end

  // counter stores
  logic              lwe, gwe;
  logic [LocalAw-1:0] lwaddr;
  logic [CtrW-1:0]   lwdata, lrdata, grdata;
  logic [CtrW-1:0]   ctr_c, ctr_new;

  tlbp_ram #(.WIDTH(CtrW), .DEPTH(Entries * RowLen)) u_local (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
    .raddr({idx_c, h_c}), .rdata(lrdata)
  );

  tlbp_ram #(.WIDTH(CtrW), .DEPTH(RowLen)) u_global (
    .clk(clk), .we(gwe), .waddr(h_q), .wdata(ctr_new),
    .raddr(h_c), .rdata(grdata)
  );

  always_comb begin
    if (shared_counters) ctr_c = gvalid[h_q] ? grdata : initial_counter;
    else ctr_c = hit_q ? lrdata : initial_counter;
    ctr_new = ctr_step(ctr_c, tk_q);
    gwe = cmd.step && op_q == OP_UPDATE && shared_counters;
    lwe = 1'b0;
    lwaddr = {idx_q, h_q};
    lwdata = ctr_new;
    if (cmd.step && op_q == OP_UPDATE && !shared_counters && !need_alloc) lwe = 1'b1;
    if (cmd.final_wr) lwe = 1'b1;
    if (cmd.sweep) begin
      lwe = 1'b1;
      lwaddr = {idx_q, sweep};
      lwdata = initial_counter;
    end
  end

  assign status.need_alloc = need_alloc;
  assign status.sweep_last = (sweep == hmask);

  logic        flush_c;
  logic [31:0] fall_q;
  assign fall_q  = pc_q + 32'd4;
  assign flush_c = tk_q ? (pred_q != tgt_q) : (pred_q != fall_q);

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= opcode;
      pc_q   <= branch_pc;
      tgt_q  <= resolved_target;
      tk_q   <= was_taken;
      pred_q <= predicted_address;
    end
    if (cmd.look) begin
      idx_q      <= idx_c;
      tag_q      <= tag_c;
      hit_q      <= hit_c;
      h_q        <= h_c;
      need_alloc <= (op_q == OP_UPDATE) && !hit_c && !shared_counters;
    end
    if (cmd.step) begin
      sweep <= '0;
      if (op_q == OP_UPDATE) begin
        entry_tag[idx_q]    <= tag_q;
        entry_target[idx_q] <= tgt_q;
      end
    end
    if (cmd.sweep) sweep <= sweep + 8'd1;
  end

  // state cleared on reset and on a config write to index 0..6
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_len         <= '0;
      history_len     <= 4'd1;
      tag_len         <= '0;
      initial_counter <= 2'd1;
      shared_history  <= 1'b0;
      shared_counters <= 1'b0;
      share_mode      <= SHARE_HIST;
      entry_valid     <= '0;
      gvalid          <= '0;
      global_history  <= '0;
      branch_count    <= '0;
      flush_count     <= '0;
      for (int i = 0; i < Entries; i++) local_history[i] <= '0;
    end else if (cfg_we && cfg_index <= REG_SHARE_MODE) begin
      case (cfg_index)
        REG_INDEX_BITS:     idx_len         <= cfg_data[2:0];
        REG_HISTORY_LEN:    history_len     <= cfg_data[3:0];
        REG_TAG_LEN:        tag_len         <= cfg_data;
        REG_INITIAL_CTR:    initial_counter <= cfg_data[1:0];
        REG_SHARED_HISTORY: shared_history  <= cfg_data[0];
        REG_SHARED_CTRS:    shared_counters <= cfg_data[0];
        REG_SHARE_MODE:     share_mode      <= cfg_data[1:0];
        default: ;
      endcase
      entry_valid    <= '0;
      gvalid         <= '0;
      global_history <= '0;
      branch_count   <= '0;
      flush_count    <= '0;
      for (int i = 0; i < Entries; i++) local_history[i] <= '0;
    end else if (cmd.step && op_q == OP_UPDATE) begin
      branch_count <= branch_count + 32'd1;
      if (flush_c) flush_count <= flush_count + 32'd1;
      entry_valid[idx_q] <= 1'b1;
      if (shared_counters) gvalid[h_q] <= 1'b1;
      if (shared_history)
        global_history <= {global_history[HistW-2:0], tk_q} & hmask;
      else
        local_history[idx_q] <=
          {(hit_q ? local_history[idx_q][HistW-2:0] : {(HistW-1){1'b0}}), tk_q} & hmask;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (op_q == OP_UPDATE) begin
        predict_taken <= 1'b0;
        next_address  <= '0;
        flush_seen    <= flush_c;
        branch_total  <= branch_count + 32'd1;
        flush_total   <= flush_count + 32'(flush_c);
      end else begin
        predict_taken <= hit_q && ctr_c[1];
        next_address  <= (hit_q && ctr_c[1]) ? entry_target[idx_q] : fall_q;
        flush_seen    <= 1'b0;
        branch_total  <= branch_count;
        flush_total   <= flush_count;
      end
    end
  end

endmodule
